// ----- design/mbrtu_pkg.sv -----
// Package for the Modbus RTU response checker.
// Holds status codes, register indexes, the stage-one beat struct and the CRC-16 fold.
// No dependencies.
package mbrtu_pkg;

	// Default limit on payload bytes in one response
	localparam int DATA_MAX_DEF = 252;

	// Byte position counter, saturating
	localparam int          POS_W   = 9;
	localparam logic [8:0]  POS_MAX = 9'd511;

	// CRC-16, reflected form
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Exception flag in the function byte
	localparam logic [7:0]  FUNC_EXC_BIT = 8'h80;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_SLAVE = 3'd2,
		ST_BAD_FUNC  = 3'd3,
		ST_EXCEPTION = 3'd4,
		ST_BAD_CRC   = 3'd5
	} status_t;

	typedef enum logic [0:0] {
		CFG_SLAVE    = 1'b0,
		CFG_FUNCTION = 1'b1
	} cfg_index_t;

	// Input beat held in the first pipeline stage
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
		logic       frame_end;
	} beat_s1_t;

	// Fold one byte into the running CRC, one bit per step
	function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

// ----- design/mbrtu_if.sv -----
// Channel interfaces for the Modbus RTU response checker.
// Received-byte channel and result channel; no package dependency.
interface mbrtu_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source (output valid, output rx_byte, output frame_end, input ready);
	modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mbrtu_res_if;
	logic       valid;
	logic       ready;
	logic       data_valid;
	logic [7:0] data_byte;
	logic       frame_done;
	logic [2:0] status;
	logic [7:0] exception_code;
	logic [7:0] data_count;

	modport source (output valid, output data_valid, output data_byte, output frame_done,
		output status, output exception_code, output data_count, input ready);
	modport sink   (input valid, input data_valid, input data_byte, input frame_done,
		input status, input exception_code, input data_count, output ready);
endinterface

// ----- design/modbus_rtu_response_checker.sv -----
// Modbus RTU response checker, top level.
// Depends on mbrtu_pkg, mbrtu_if, mbrtu_in_stage and mbrtu_frame.
//
// Usage:
//   rx carries one received response byte per beat, frame_end set on the
//   last byte. result carries at most one beat per received byte: a payload
//   byte released two bytes late (so the CRC bytes never appear), and on the
//   last byte the frame status, payload count and exception code.
//   The config port writes expected_slave (index 0) and expected_function
//   (index 1) with cfg_we; change them only between frames.
// Path: a byte taken from rx goes into the input register, and its result beat
//   into the result register, from which result shows it.
// Throughput: one byte per cycle while result is not stalled; the input register
//   and the result register each hold one beat, and the CRC-16 fold of a byte is combinational.
// Reset: arst_n clears the frame state, empties both registers, and sets
//   expected_slave to 0 and expected_function to 3.
// Stall: while result.ready is low the result beat holds; a byte that makes
//   no result still moves through, and a byte that makes one waits in the
//   input register, after which rx.ready drops.
module modbus_rtu_response_checker
	import mbrtu_pkg::*;
#(
	parameter int DATA_MAX = DATA_MAX_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	mbrtu_rx_if.sink    rx,
	mbrtu_res_if.source result
);

	beat_s1_t beat_s1;
	logic     advance;

	mbrtu_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.advance (advance),
		.beat_s1 (beat_s1)
	);

	mbrtu_frame #(
		.DATA_MAX (DATA_MAX)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.beat_s1   (beat_s1),
		.advance   (advance),
		.result    (result)
	);

endmodule

// ----- design/mbrtu_in_stage.sv -----
// Input register stage of the Modbus RTU response checker.
// Depends on mbrtu_pkg (beat_s1_t) and mbrtu_rx_if.
module mbrtu_in_stage
	import mbrtu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mbrtu_rx_if.sink    rx,
	input  logic        advance,
	output beat_s1_t    beat_s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Take a new beat whenever the stage is empty or moves on this cycle
	assign rx.ready = !valid_s1 || advance;

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// Capture payload on accept
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			end_s1  <= rx.frame_end;
		end
	end

	assign beat_s1 = '{valid: valid_s1, rx_byte: byte_s1, frame_end: end_s1};

endmodule

// ----- design/mbrtu_frame.sv -----
// Frame state, CRC check, status decision and result register of the response checker.
// Depends on mbrtu_pkg (crc_fold, status_t, cfg_index_t, beat_s1_t) and mbrtu_res_if.
module mbrtu_frame
	import mbrtu_pkg::*;
#(
	parameter int DATA_MAX = DATA_MAX_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  beat_s1_t    beat_s1,
	output logic        advance,
	mbrtu_res_if.source result
);

	localparam logic [9:0] DV_END   = 10'(DATA_MAX + 4);
	localparam logic [9:0] LONG_TH  = 10'(DATA_MAX + 3);

	// Configuration
	logic [7:0]       exp_slave_q;
	logic [6:0]       exp_func_q;

	// Frame state
	logic [15:0]      crc_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       dly0_q;
	logic [7:0]       dly1_q;
	logic [7:0]       seen_slave_q;
	logic [7:0]       seen_func_q;
	logic [7:0]       first_data_q;

	// Result register
	logic             out_valid_q;
	logic             data_valid_q;
	logic [7:0]       data_byte_q;
	logic             frame_done_q;
	status_t          status_q;
	logic [7:0]       exc_q;
	logic [7:0]       count_q;

	logic [9:0]       pos_w;
	logic [15:0]      crc_next;
	logic             dv;
	logic             has_result;
	status_t          st;
	logic [7:0]       exc;
	logic [7:0]       cnt;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_slave_q <= 8'd0;
			exp_func_q  <= 7'd3;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SLAVE:    exp_slave_q <= cfg_wdata;
				CFG_FUNCTION: exp_func_q  <= cfg_wdata[6:0];
				default:      ;
			endcase
		end
	end

	// Release the byte two positions back while it is payload
	always_comb begin
		pos_w    = {1'b0, pos_q};
		crc_next = crc_fold(crc_q, beat_s1.rx_byte);
		dv       = (pos_w >= 10'd4) && (pos_w < DV_END);
	end

	// Decide frame status, checks in priority order
	always_comb begin
		st  = ST_OK;
		exc = 8'd0;
		cnt = 8'd0;
		if (beat_s1.frame_end) begin
			if (pos_w < 10'd4) begin
				st = ST_SHORT;
			end else if (pos_w > LONG_TH) begin
				st = ST_BAD_CRC;
			end else begin
				cnt = 8'(pos_w - 10'd3);
				if (seen_slave_q != exp_slave_q) begin
					st = ST_BAD_SLAVE;
				end else if (seen_func_q[6:0] != exp_func_q) begin
					st = ST_BAD_FUNC;
				end else if ((seen_func_q & FUNC_EXC_BIT) != 8'd0) begin
					st  = ST_EXCEPTION;
					exc = first_data_q;
				end else if (crc_next != 16'd0) begin
					st = ST_BAD_CRC;
				end else begin
					st = ST_OK;
				end
			end
		end
	end

	// Move the beat on when it needs no slot or the result register frees up
	assign has_result = dv || beat_s1.frame_end;
	assign advance    = beat_s1.valid && (!has_result || !out_valid_q || result.ready);

	// Advance frame state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_INIT;
			pos_q        <= '0;
			dly0_q       <= 8'd0;
			dly1_q       <= 8'd0;
			seen_slave_q <= 8'd0;
			seen_func_q  <= 8'd0;
			first_data_q <= 8'd0;
		end else if (advance) begin
			if (beat_s1.frame_end) begin
				crc_q        <= CRC_INIT;
				pos_q        <= '0;
				dly0_q       <= 8'd0;
				dly1_q       <= 8'd0;
				seen_slave_q <= 8'd0;
				seen_func_q  <= 8'd0;
				first_data_q <= 8'd0;
			end else begin
				crc_q  <= crc_next;
				dly0_q <= beat_s1.rx_byte;
				dly1_q <= dly0_q;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 9'd1;
				end
				if (pos_q == 9'd0) begin
					seen_slave_q <= beat_s1.rx_byte;
				end
				if (pos_q == 9'd1) begin
					seen_func_q <= beat_s1.rx_byte;
				end
				if (pos_q == 9'd2) begin
					first_data_q <= beat_s1.rx_byte;
				end
			end
		end
	end

	// Hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			data_valid_q <= dv;
			data_byte_q  <= dv ? dly1_q : 8'd0;
			frame_done_q <= beat_s1.frame_end;
			status_q     <= st;
			exc_q        <= exc;
			count_q      <= cnt;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.data_valid     = data_valid_q;
	assign result.data_byte      = data_byte_q;
	assign result.frame_done     = frame_done_q;
	assign result.status         = status_q;
	assign result.exception_code = exc_q;
	assign result.data_count     = count_q;

endmodule

// ----- design/mbrtu_checker.sv -----
// Port-level assertions for the Modbus RTU response checker, bound to the top level.
// Depends on mbrtu_pkg (status_t) and modbus_rtu_response_checker.
module mbrtu_checker
	import mbrtu_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       data_valid,
	input logic [7:0] data_byte,
	input logic       frame_done,
	input logic [2:0] status,
	input logic [7:0] exception_code,
	input logic [7:0] data_count
);

	// Stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(data_byte)
			&& $stable(data_count))
		else $error("result beat changed while stalled");

	// A beat carries a payload byte or a frame status
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> data_valid || frame_done)
		else $error("empty result beat");

	// Status fields are zero outside the last byte's beat
	a_idle_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !frame_done |-> status == ST_OK && data_count == 8'd0
			&& exception_code == 8'd0)
		else $error("status fields set before frame end");

	// Exception code only with an exception status
	a_exc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_EXCEPTION |-> exception_code == 8'd0)
		else $error("exception code without exception status");

	// Short frames report no payload and no data byte
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done && status == ST_SHORT |-> data_count == 8'd0 && !data_valid)
		else $error("short frame with payload");

endmodule

bind modbus_rtu_response_checker mbrtu_checker u_mbrtu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.data_valid     (result.data_valid),
	.data_byte      (result.data_byte),
	.frame_done     (result.frame_done),
	.status         (result.status),
	.exception_code (result.exception_code),
	.data_count     (result.data_count)
);

// ----- sim/tb_modbus_rtu_response_checker.sv -----
// Testbench for modbus_rtu_response_checker: random response frames in bursts,
// a bit-level model of the CRC-16 checker, and field checks on every result beat.
// Depends on mbrtu_pkg, mbrtu_if and the design under test.
module tb_modbus_rtu_response_checker;
	import mbrtu_pkg::*;

	localparam int PAYLOAD_LIMIT = DATA_MAX_DEF;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_BYTES   = 24;

	typedef struct packed {
		logic       value;
		logic [7:0] octet;
	} rx_item_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic       frame_done;
		status_t    status;
		logic [7:0] exception_code;
		logic [7:0] data_count;
	} response_t;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_MOSTLY,
		RDY_RARELY,
		RDY_PERIODIC
	} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	cfg_index_t  cfg_index;
	logic [7:0]  cfg_wdata;

	mbrtu_rx_if  rx_bus();
	mbrtu_res_if res_bus();

	modbus_rtu_response_checker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.rx       (rx_bus),
		.result   (res_bus)
	);

	always #5 clk = ~clk;

	// Frame model state and register copies
	logic [15:0] frame_crc;
	logic [8:0]  frame_pos;
	logic [7:0]  lag_bytes [2];
	logic [7:0]  seen_slave;
	logic [7:0]  seen_func;
	logic [7:0]  first_data;
	logic [7:0]  want_slave;
	logic [6:0]  want_func;

	rx_item_t    rx_backlog [$];
	response_t   awaited_results [$];
	int          queued_bytes;
	int          mismatches;
	int          cycle_count;

	// Sender and receiver pacing
	int          burst_left;
	int          gap_left;
	rx_item_t    next_item;
	ready_mode_t ready_mode;
	int          ready_hold;
	int          ready_tick;

	// Fold one byte into the CRC, one input bit at a time
	function automatic logic [15:0] crc_after_byte(input logic [15:0] crc,
		input logic [7:0] octet);
		logic [15:0] acc;
		logic        feedback;
		acc = crc;
		for (int i = 0; i < 8; i++) begin
			feedback = acc[0] ^ octet[i];
			acc = {1'b0, acc[15:1]};
			if (feedback) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	task automatic clear_frame_model();
		frame_crc    = CRC_INIT;
		frame_pos    = '0;
		lag_bytes[0] = '0;
		lag_bytes[1] = '0;
		seen_slave   = '0;
		seen_func    = '0;
		first_data   = '0;
	endtask

	// Advance the model by one accepted byte and queue the result it causes
	task automatic advance_frame_model(input logic [7:0] octet, input logic is_last);
		response_t  beat;
		logic [9:0] pos;
		logic [9:0] span;
		logic       release_now;
		pos  = {1'b0, frame_pos};
		span = pos + 10'd1;
		frame_crc = crc_after_byte(frame_crc, octet);
		if (pos == 0) begin
			seen_slave = octet;
		end else if (pos == 1) begin
			seen_func = octet;
		end else if (pos == 2) begin
			first_data = octet;
		end
		// byte two positions back is payload once it sits at position 2 or later, up to PAYLOAD_LIMIT bytes
		release_now = (pos >= 4) && ((pos - 10'd4) < PAYLOAD_LIMIT);
		beat = '0;
		beat.data_valid = release_now;
		beat.data_byte  = release_now ? lag_bytes[1] : 8'h00;
		lag_bytes[1] = lag_bytes[0];
		lag_bytes[0] = octet;
		if (frame_pos < POS_MAX) begin
			frame_pos = frame_pos + 9'd1;
		end
		if (is_last) begin
			beat.frame_done = 1'b1;
			if (span < 5) begin
				beat.status = ST_SHORT;
			end else if ((span - 10'd4) > PAYLOAD_LIMIT) begin
				beat.status = ST_BAD_CRC;
			end else begin
				beat.data_count = 8'(span - 10'd4);
				if (seen_slave != want_slave) begin
					beat.status = ST_BAD_SLAVE;
				end else if (seen_func[6:0] != want_func) begin
					beat.status = ST_BAD_FUNC;
				end else if ((seen_func & FUNC_EXC_BIT) != 0) begin
					beat.status = ST_EXCEPTION;
					beat.exception_code = first_data;
				end else if (frame_crc != 16'h0000) begin
					beat.status = ST_BAD_CRC;
				end else begin
					beat.status = ST_OK;
				end
			end
		end
		if (release_now || is_last) begin
			awaited_results.push_back(beat);
		end
		if (is_last) begin
			clear_frame_model();
		end
	endtask

	task automatic compare_field(input string field, input logic [7:0] want,
		input logic [7:0] seen);
		if (seen !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
			mismatches++;
		end
	endtask

	task automatic compare_result(input response_t want);
		compare_field("data_valid", 8'(want.data_valid), 8'(res_bus.data_valid));
		compare_field("data_byte", want.data_byte, res_bus.data_byte);
		compare_field("frame_done", 8'(want.frame_done), 8'(res_bus.frame_done));
		compare_field("status", 8'(want.status), 8'(res_bus.status));
		compare_field("exception_code", want.exception_code, res_bus.exception_code);
		compare_field("data_count", want.data_count, res_bus.data_count);
	endtask

	task automatic push_rx_byte(input logic [7:0] octet, input logic is_last);
		rx_item_t item;
		item.octet = octet;
		item.value = is_last;
		rx_backlog.push_back(item);
		queued_bytes++;
	endtask

	// Build one response frame; cut_len > 0 and below the frame length ends it early on that byte
	task automatic queue_frame(input logic [7:0] slave_id, input logic [7:0] func_code,
		input int payload_len, input bit corrupt_crc, input int cut_len);
		logic [7:0]  frame_bytes [$];
		logic [15:0] crc;
		int          keep;
		int          hit;
		frame_bytes.push_back(slave_id);
		frame_bytes.push_back(func_code);
		repeat (payload_len) frame_bytes.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (frame_bytes[i]) begin
			crc = crc_after_byte(crc, frame_bytes[i]);
		end
		frame_bytes.push_back(crc[7:0]);
		frame_bytes.push_back(crc[15:8]);
		if (corrupt_crc) begin
			hit = frame_bytes.size() - 1 - $urandom_range(0, 1);
			frame_bytes[hit] = frame_bytes[hit] ^ 8'(1 << $urandom_range(0, 7));
		end
		keep = (cut_len > 0 && cut_len < frame_bytes.size()) ? cut_len : frame_bytes.size();
		for (int i = 0; i < keep; i++) begin
			push_rx_byte(frame_bytes[i], i == keep - 1);
		end
	endtask

	// Mostly well-formed frames for the current setting, the rest broken or noise
	task automatic queue_random_frame();
		int         kind;
		int         payload_len;
		int         noise_len;
		logic [7:0] func_code;
		kind = $urandom_range(0, 99);
		payload_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) :
			$urandom_range(1, 8);
		if (kind < 55) begin
			queue_frame(want_slave, {1'b0, want_func}, payload_len, 1'b0, 0);
		end else if (kind < 63) begin
			queue_frame(want_slave, {1'b0, want_func}, payload_len, 1'b1, 0);
		end else if (kind < 70) begin
			queue_frame(want_slave, {1'b1, want_func}, $urandom_range(1, 3),
				1'($urandom_range(0, 1)), 0);
		end else if (kind < 76) begin
			queue_frame(want_slave ^ 8'($urandom_range(1, 255)), {1'b0, want_func},
				payload_len, 1'b0, 0);
		end else if (kind < 82) begin
			func_code = 8'($urandom);
			while (func_code[6:0] == want_func) func_code = 8'($urandom);
			queue_frame(want_slave, func_code, payload_len, 1'b0, 0);
		end else if (kind < 90) begin
			queue_frame(want_slave, {1'b0, want_func}, payload_len, 1'b0,
				$urandom_range(1, payload_len + 3));
		end else begin
			noise_len = $urandom_range(1, 8);
			for (int i = 0; i < noise_len; i++) begin
				push_rx_byte(8'($urandom), i == noise_len - 1);
			end
		end
	endtask

	// Hold until every byte is taken and every result has come, then let it settle
	task automatic wait_idle();
		@(negedge clk);
		while (rx_backlog.size() != 0 || rx_bus.valid || awaited_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t index, input logic [7:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		if (index == CFG_SLAVE) begin
			want_slave = value;
		end else begin
			want_func = value[6:0];
		end
	endtask

	task automatic apply_setting(input logic [7:0] slave_id, input logic [6:0] func_code);
		write_register(CFG_SLAVE, slave_id);
		// bit 7 of the function write is dropped by the block
		write_register(CFG_FUNCTION, {1'($urandom), func_code});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drive the byte channel in bursts with random gaps; predict at each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_bus.valid     <= 1'b0;
			rx_bus.rx_byte   <= 8'h00;
			rx_bus.frame_end <= 1'b0;
			burst_left       <= 1;
			gap_left         <= 0;
		end else begin
			if (rx_bus.valid && rx_bus.ready) begin
				advance_frame_model(rx_bus.rx_byte, rx_bus.frame_end);
			end
			if (!rx_bus.valid || rx_bus.ready) begin
				if (gap_left != 0) begin
					gap_left     <= gap_left - 1;
					rx_bus.valid <= 1'b0;
				end else if (rx_backlog.size() != 0) begin
					next_item = rx_backlog.pop_front();
					rx_bus.valid     <= 1'b1;
					rx_bus.rx_byte   <= next_item.octet;
					rx_bus.frame_end <= next_item.value;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					rx_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Check each result beat against the oldest expectation; stall on a mode pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			ready_mode    <= RDY_ALWAYS;
			ready_hold    <= 0;
			ready_tick    <= 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with no expected result: data_valid %0b frame_done %0b",
						res_bus.data_valid, res_bus.frame_done);
					mismatches++;
				end else begin
					compare_result(awaited_results.pop_front());
				end
			end
			ready_tick <= ready_tick + 1;
			if (ready_hold == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 3));
				ready_hold <= $urandom_range(20, 120);
			end else begin
				ready_hold <= ready_hold - 1;
			end
			case (ready_mode)
				RDY_ALWAYS: begin
					res_bus.ready <= 1'b1;
				end
				RDY_MOSTLY: begin
					res_bus.ready <= ($urandom_range(0, 3) != 0);
				end
				RDY_RARELY: begin
					res_bus.ready <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					res_bus.ready <= (ready_tick % 3 != 0);
				end
			endcase
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int phase_start;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_SLAVE;
		cfg_wdata        = 8'h00;
		queued_bytes     = 0;
		clear_frame_model();
		want_slave = 8'h00;
		want_func  = 7'd3;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames at the reset setting: slave 0, function 3
		push_rx_byte(8'h00, 1'b1);                  // single byte, short
		queue_frame(8'h00, 8'h03, 0, 1'b0, 0);      // four bytes with good CRC, still short
		queue_frame(8'h00, 8'h03, 1, 1'b0, 0);      // shortest good frame
		queue_frame(8'hFF, 8'h03, 1, 1'b0, 0);      // wrong slave
		queue_frame(8'h00, 8'h04, 1, 1'b0, 0);      // wrong function
		queue_frame(8'h00, 8'h83, 1, 1'b1, 0);      // exception wins over a bad CRC
		queue_frame(8'h00, 8'h03, 1, 1'b1, 0);      // bad CRC
		wait_idle();

		// Random frames under several settings, extremes included
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: apply_setting(8'hFF, 7'h7F);
				1: apply_setting(8'h00, 7'h00);
				2: apply_setting(8'($urandom_range(1, 254)), 7'($urandom_range(1, 126)));
				3: apply_setting(8'h11, 7'h10);
				default: apply_setting(8'hF7, 7'h03);
			endcase
			phase_start = queued_bytes;
			while (queued_bytes - phase_start < PHASE_BYTES) begin
				queue_random_frame();
				// in phase 2, pause the sender mid-phase until every result is in
				if (phase == 2 && queued_bytes - phase_start >= PHASE_BYTES / 2 &&
						queued_bytes - phase_start < PHASE_BYTES / 2 + 12) begin
					wait_idle();
					phase_start = phase_start - 12;
				end
			end
			wait_idle();
		end

		// One payload byte over the limit, then a short good frame after it
		queue_frame(want_slave, {1'b0, want_func}, PAYLOAD_LIMIT + 1, 1'b0, 0);
		queue_frame(want_slave, {1'b0, want_func}, 2, 1'b0, 0);
		wait_idle();

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/mbrtu_pkg.sv
design/mbrtu_if.sv
design/mbrtu_in_stage.sv
design/mbrtu_frame.sv
design/modbus_rtu_response_checker.sv
design/mbrtu_checker.sv
sim/tb_modbus_rtu_response_checker.sv
